/* hdl/multiply_divide_register_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the multiply/divide register unit
// Concurrent assertion shorthands clocked on clk and disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef MULTIPLY_DIVIDE_REGISTER_UNIT_ASSERT_SVH
`define MULTIPLY_DIVIDE_REGISTER_UNIT_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define MDRU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("multiply/divide unit: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define MDRU_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("multiply/divide unit: same-cycle check failed");

`endif

/* hdl/mdru_pkg.sv */
// ----------------------------------------------------------------------------
// Multiply/divide register unit package
// Register offsets, request commands, reset values and sequencer last-step indices.
// ----------------------------------------------------------------------------
package mdru_pkg;

	// Request commands.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Register offsets within the 32-byte window.
	localparam logic [4:0] OFF_MULTIPLICAND = 5'h02;
	localparam logic [4:0] OFF_MULTIPLY     = 5'h03;
	localparam logic [4:0] OFF_DIVIDEND_LO  = 5'h04;
	localparam logic [4:0] OFF_DIVIDEND_HI  = 5'h05;
	localparam logic [4:0] OFF_DIVIDE       = 5'h06;
	localparam logic [4:0] OFF_QUOT_LO      = 5'h14;
	localparam logic [4:0] OFF_QUOT_HI      = 5'h15;
	localparam logic [4:0] OFF_PROD_LO      = 5'h16;
	localparam logic [4:0] OFF_PROD_HI      = 5'h17;

	// Register values after reset.
	localparam logic [7:0]  RST_MULTIPLICAND = 8'hFF;
	localparam logic [15:0] RST_DIVIDEND     = 16'hFFFF;
	localparam logic [15:0] RST_QUOTIENT     = 16'h0101;
	localparam logic [15:0] RST_PRODREM      = 16'hFE01;

	// Quotient returned for a divide by zero.
	localparam logic [15:0] QUOT_DIV_ZERO = 16'hFFFF;

	// Index of the last step of each iterative operation.
	localparam logic [3:0] MUL_LAST = 4'd7;
	localparam logic [3:0] DIV_LAST = 4'd15;

endpackage

/* hdl/multiply_divide_register_unit.sv */
// ----------------------------------------------------------------------------
// Multiply/divide register unit
// Byte-wide register window with an 8x8 multiplier and a 16/8 divider that
// share one 9-bit adder/subtractor under a small step sequencer.
// ----------------------------------------------------------------------------
//  Channel  | Handshake          | Payload
//  ---------+--------------------+------------------------------------------
//  in       | in_valid, in_stall | command, reg_offset, write_data
//  out      | out_valid,out_stall| read_data
//
// Every request gives one response in the output register on the cycle after
// acceptance. A write to the multiply offset then keeps the unit busy for
// one adder pass per multiplier bit; a write to the divide offset with a
// non-zero divisor keeps it busy for one restoring step per dividend bit.
// in_stall is high while the sequencer runs or while an unclaimed response is
// held against out_stall.
// Reset is asynchronous and needs no further initialisation time.
module multiply_divide_register_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       command,
	input  logic [4:0] reg_offset,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data
);
	import mdru_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MUL  = 3'b010,
		ST_DIV  = 3'b100
	} state_t;

	state_t      state_q;
	logic [3:0]  count_q;
	logic        out_valid_q;
	logic [7:0]  read_data_q;

	logic [7:0]  multiplicand_q;
	logic [15:0] dividend_q;
	logic [15:0] quotient_q;
	logic [15:0] prodrem_q;

	// Working registers of the shared unit.
	logic [7:0]  acc_q;
	logic [15:0] shift_q;
	logic [7:0]  opnd_q;

	logic        accept;
	logic        alu_sub;
	logic [8:0]  alu_a;
	logic [8:0]  alu_b;
	logic [9:0]  alu_res;
	logic        no_borrow;
	logic [7:0]  acc_next;
	logic [15:0] shift_next;
	logic [7:0]  rd_value;

	// Request handshake.
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);

	// Shared adder/subtractor: adds the multiplicand when the current multiplier
	// bit is set, and subtracts the divisor from the partial remainder when dividing.
	always_comb begin
		alu_sub = (state_q == ST_DIV);
		if (alu_sub) begin
			alu_a = {acc_q, shift_q[15]};
			alu_b = {1'b0, opnd_q};
		end else begin
			alu_a = {1'b0, acc_q};
			alu_b = shift_q[0] ? {1'b0, multiplicand_q} : 9'd0;
		end
		alu_res   = {1'b0, alu_a} + {1'b0, alu_b ^ {9{alu_sub}}} + {9'd0, alu_sub};
		no_borrow = alu_res[9];
	end

	// Next values of the working registers for one step.
	always_comb begin
		if (alu_sub) begin
			acc_next   = no_borrow ? alu_res[7:0] : alu_a[7:0];
			shift_next = {shift_q[14:0], no_borrow};
		end else begin
			acc_next   = alu_res[8:1];
			shift_next = {shift_q[15:8], alu_res[0], shift_q[7:1]};
		end
	end

	// Read-back selection.
	always_comb begin
		case (reg_offset)
			OFF_QUOT_LO: rd_value = quotient_q[7:0];
			OFF_QUOT_HI: rd_value = quotient_q[15:8];
			OFF_PROD_LO: rd_value = prodrem_q[7:0];
			OFF_PROD_HI: rd_value = prodrem_q[15:8];
			default:     rd_value = 8'd0;
		endcase
	end

	// Sequencer and architectural registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= 4'd0;
			multiplicand_q <= RST_MULTIPLICAND;
			dividend_q     <= RST_DIVIDEND;
			quotient_q     <= RST_QUOTIENT;
			prodrem_q      <= RST_PRODREM;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && command == CMD_WRITE) begin
						case (reg_offset)
							OFF_MULTIPLICAND: multiplicand_q <= write_data;
							OFF_DIVIDEND_LO:  dividend_q[7:0] <= write_data;
							OFF_DIVIDEND_HI:  dividend_q[15:8] <= write_data;
							OFF_MULTIPLY: begin
								state_q <= ST_MUL;
								count_q <= MUL_LAST;
							end
							OFF_DIVIDE: begin
								if (write_data == 8'd0) begin
									quotient_q <= QUOT_DIV_ZERO;
									prodrem_q  <= dividend_q;
								end else begin
									state_q <= ST_DIV;
									count_q <= DIV_LAST;
								end
							end
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					count_q <= count_q - 4'd1;
					if (count_q == 4'd0) begin
						prodrem_q <= {acc_next, shift_next[7:0]};
						state_q   <= ST_IDLE;
					end
				end
				ST_DIV: begin
					count_q <= count_q - 4'd1;
					if (count_q == 4'd0) begin
						quotient_q <= shift_next;
						prodrem_q  <= {8'd0, acc_next};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers: loaded on a request, stepped while busy.
	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q   <= 8'd0;
			opnd_q  <= write_data;
			shift_q <= (reg_offset == OFF_MULTIPLY) ? {8'd0, write_data} : dividend_q;
		end else if (state_q != ST_IDLE) begin
			acc_q   <= acc_next;
			shift_q <= shift_next;
		end
	end

	// Output register: the response is known when the request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q <= (command == CMD_READ) ? rd_value : 8'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

endmodule

/* hdl/mdru_checker.sv */
// ----------------------------------------------------------------------------
// Multiply/divide register unit checker
// Port-level assertions on the response timing and contents of the unit.
// ----------------------------------------------------------------------------
`include "multiply_divide_register_unit_assert.svh"

module mdru_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       command,
	input logic [4:0] reg_offset,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] read_data
);
	import mdru_pkg::*;

	logic req_take;
	logic rd_unmapped;

	assign req_take    = in_valid && !in_stall;
	assign rd_unmapped = (reg_offset != OFF_QUOT_LO) && (reg_offset != OFF_QUOT_HI) &&
	                     (reg_offset != OFF_PROD_LO) && (reg_offset != OFF_PROD_HI);

	// A held response keeps its value until it is taken.
	`MDRU_ASSERT_NEXT(a_resp_hold, out_valid && out_stall, out_valid && $stable(read_data))

	// Every accepted request shows a response on the next cycle.
	`MDRU_ASSERT_NEXT(a_resp_next, req_take, out_valid)

	// Writes answer with a zero byte.
	`MDRU_ASSERT_NEXT(a_write_zero, req_take && command == CMD_WRITE, read_data == 8'd0)

	// Reads outside the result registers answer with a zero byte.
	`MDRU_ASSERT_NEXT(a_read_unmapped, req_take && command == CMD_READ && rd_unmapped,
		read_data == 8'd0)

	// A multiply request occupies the unit on the following cycle.
	`MDRU_ASSERT_NEXT(a_mul_busy, req_take && command == CMD_WRITE &&
		reg_offset == OFF_MULTIPLY, in_stall)

endmodule

bind multiply_divide_register_unit mdru_checker u_mdru_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.command    (command),
	.reg_offset (reg_offset),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.read_data  (read_data)
);

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// Testbench for the multiply/divide register unit
// Drives register requests through the valid/stall channel and checks every
// response byte against a cycle-free model of the multiplicand, dividend,
// quotient and product/remainder registers in the bench, or a hand-typed byte
// for fixed directed rows. A short table of directed requests comes first, then
// random multiply and divide sequences, stray accesses, and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import mdru_pkg::*;

	// Offsets outside every modelled register.
	localparam logic [4:0] OFF_SPARE_LO = 5'h00;
	localparam logic [4:0] OFF_SPARE_HI = 5'h1F;

	localparam int DIRECTED_COUNT = 26;
	localparam int TOTAL_REQUESTS = 1450;
	localparam int CALM_TAIL      = 150;
	localparam int IDLE_LIMIT     = 3000;
	localparam int DRAIN_CYCLES   = 40;

	// One row of the directed table: the request, and where "fixed" is set,
	// the response byte typed in by hand instead of taken from the model.
	typedef struct packed {
		logic       cmd;
		logic [4:0] off;
		logic [7:0] data;
		logic       fixed;
		logic [7:0] want;
	} access_row_t;

	typedef struct {
		logic [7:0] value;
		int         item;
	} read_expect_t;

	localparam access_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
		'{CMD_READ,  OFF_QUOT_LO,      8'h00, 1'b1, 8'h01},
		'{CMD_READ,  OFF_QUOT_HI,      8'h00, 1'b1, 8'h01},
		'{CMD_READ,  OFF_PROD_HI,      8'h00, 1'b1, 8'hFE},
		'{CMD_READ,  OFF_SPARE_LO,     8'hFF, 1'b1, 8'h00},
		'{CMD_READ,  OFF_SPARE_HI,     8'h00, 1'b1, 8'h00},
		'{CMD_WRITE, OFF_MULTIPLY,     8'hFF, 1'b1, 8'h00},
		'{CMD_READ,  OFF_PROD_LO,      8'h00, 1'b1, 8'h01},
		'{CMD_WRITE, OFF_MULTIPLICAND, 8'h00, 1'b1, 8'h00},
		'{CMD_WRITE, OFF_MULTIPLY,     8'hFF, 1'b1, 8'h00},
		'{CMD_READ,  OFF_PROD_HI,      8'h00, 1'b1, 8'h00},
		'{CMD_WRITE, OFF_DIVIDEND_LO,  8'hFF, 1'b1, 8'h00},
		'{CMD_WRITE, OFF_DIVIDEND_HI,  8'hFF, 1'b1, 8'h00},
		'{CMD_WRITE, OFF_DIVIDE,       8'h00, 1'b1, 8'h00},
		'{CMD_READ,  OFF_QUOT_HI,      8'h00, 1'b1, 8'hFF},
		'{CMD_READ,  OFF_PROD_LO,      8'h00, 1'b1, 8'hFF},
		'{CMD_WRITE, OFF_DIVIDE,       8'h01, 1'b1, 8'h00},
		'{CMD_READ,  OFF_PROD_HI,      8'h00, 1'b1, 8'h00},
		'{CMD_WRITE, OFF_DIVIDEND_HI,  8'h00, 1'b1, 8'h00},
		'{CMD_WRITE, OFF_DIVIDEND_LO,  8'h00, 1'b1, 8'h00},
		'{CMD_WRITE, OFF_DIVIDE,       8'hFF, 1'b1, 8'h00},
		'{CMD_READ,  OFF_QUOT_LO,      8'h00, 1'b0, 8'h00},
		'{CMD_WRITE, OFF_QUOT_LO,      8'h55, 1'b1, 8'h00},
		'{CMD_READ,  OFF_QUOT_HI,      8'hFF, 1'b0, 8'h00},
		'{CMD_WRITE, OFF_MULTIPLICAND, 8'h80, 1'b1, 8'h00},
		'{CMD_WRITE, OFF_MULTIPLY,     8'h7F, 1'b1, 8'h00},
		'{CMD_READ,  OFF_PROD_HI,      8'h00, 1'b0, 8'h00}
	};

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_stall;
	logic       command    = CMD_WRITE;
	logic [4:0] reg_offset = 5'h00;
	logic [7:0] write_data = 8'h00;
	logic       out_valid;
	logic       out_stall  = 1'b0;
	logic [7:0] read_data;

	// Register copies held by the bench, starting from their reset values.
	logic [7:0]  model_mcand    = RST_MULTIPLICAND;
	logic [15:0] model_dividend = RST_DIVIDEND;
	logic [15:0] model_quotient = RST_QUOTIENT;
	logic [15:0] model_prodrem  = RST_PRODREM;

	read_expect_t expected_bytes [$];
	read_expect_t oldest;
	int           mismatches   = 0;
	int           sent_count   = 0;
	int           idle_cycles  = 0;
	int           stall_left   = 0;
	bit           calm         = 1'b0;

	multiply_divide_register_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.reg_offset (reg_offset),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Applies one accepted request to the register copies and returns the
	// byte the unit should answer with.
	task automatic predict_access(input logic cmd, input logic [4:0] off,
			input logic [7:0] data, output logic [7:0] answer);
		logic [15:0] divisor;
		divisor = {8'h00, data};
		answer  = 8'h00;
		if (cmd == CMD_READ) begin
			case (off)
				OFF_QUOT_LO: answer = model_quotient[7:0];
				OFF_QUOT_HI: answer = model_quotient[15:8];
				OFF_PROD_LO: answer = model_prodrem[7:0];
				OFF_PROD_HI: answer = model_prodrem[15:8];
				default:     answer = 8'h00;
			endcase
		end else begin
			case (off)
				OFF_MULTIPLICAND: model_mcand = data;
				OFF_MULTIPLY:     model_prodrem = {8'h00, model_mcand} * divisor;
				OFF_DIVIDEND_LO:  model_dividend[7:0] = data;
				OFF_DIVIDEND_HI:  model_dividend[15:8] = data;
				OFF_DIVIDE: begin
					// A zero divisor saturates the quotient and leaves the
					// dividend in the remainder.
					if (data == 8'h00) begin
						model_quotient = QUOT_DIV_ZERO;
						model_prodrem  = model_dividend;
					end else begin
						model_quotient = model_dividend / divisor;
						model_prodrem  = model_dividend % divisor;
					end
				end
				default: ;
			endcase
		end
	endtask

	task automatic report_mismatch(input string what, input int item,
			input logic [7:0] want, input logic [7:0] got);
		$display("MISMATCH %s: request %0d expected %02h got %02h", what, item, want, got);
		mismatches++;
	endtask

	// Presents one request, waits for it to be taken, and queues the answer.
	task automatic send_request(input logic cmd, input logic [4:0] off,
			input logic [7:0] data, input logic fixed, input logic [7:0] want);
		logic [7:0]   answer;
		read_expect_t entry;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		reg_offset <= off;
		write_data <= data;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_access(cmd, off, data, answer);
		entry.value = fixed ? want : answer;
		entry.item  = sent_count;
		expected_bytes.push_back(entry);
		sent_count++;
	endtask

	task automatic send_write(input logic [4:0] off, input logic [7:0] data);
		send_request(CMD_WRITE, off, data, 1'b0, 8'h00);
	endtask

	task automatic send_read(input logic [4:0] off);
		send_request(CMD_READ, off, 8'($urandom), 1'b0, 8'h00);
	endtask

	// Operand byte leaning towards the extremes.
	function automatic logic [7:0] pick_operand();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h01;
			default: return 8'($urandom);
		endcase
	endfunction

	// Holds the sender back until every queued response has been returned.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
	endtask

	// Optional multiplicand, multiply, then some of the product bytes.
	task automatic run_multiply_sequence();
		if ($urandom_range(0, 3) != 0)
			send_write(OFF_MULTIPLICAND, pick_operand());
		send_write(OFF_MULTIPLY, pick_operand());
		if ($urandom_range(0, 1) == 0) begin
			send_read(OFF_PROD_LO);
			send_read(OFF_PROD_HI);
		end else begin
			send_read(OFF_PROD_HI);
			if ($urandom_range(0, 1) == 0)
				send_read(OFF_PROD_LO);
		end
	endtask

	// Optional dividend bytes, divide, then some quotient and remainder bytes.
	task automatic run_divide_sequence();
		if ($urandom_range(0, 3) != 0)
			send_write(OFF_DIVIDEND_LO, pick_operand());
		if ($urandom_range(0, 3) != 0)
			send_write(OFF_DIVIDEND_HI, pick_operand());
		send_write(OFF_DIVIDE, pick_operand());
		send_read(OFF_QUOT_LO);
		if ($urandom_range(0, 3) != 0)
			send_read(OFF_QUOT_HI);
		send_read(OFF_PROD_LO);
		if ($urandom_range(0, 3) != 0)
			send_read(OFF_PROD_HI);
	endtask

	// Stray accesses anywhere in the window.
	task automatic run_stray_accesses();
		repeat ($urandom_range(1, 4))
			send_request(1'($urandom), 5'($urandom), 8'($urandom), 1'b0, 8'h00);
	endtask

	// Receiver: stalls in random bursts; no new burst starts while calm.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			out_stall  <= 1'b1;
			stall_left = $urandom_range(1, 13) - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Response checker: each response must match the oldest queued answer.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("unexpected response", -1, 8'h00, read_data);
			end else begin
				oldest = expected_bytes.pop_front();
				if (read_data !== oldest.value)
					report_mismatch("read_data", oldest.item, oldest.value, read_data);
			end
		end
	end

	// Watchdog: ends the run when neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("watchdog expired with %0d responses outstanding",
						expected_bytes.size());
					$display("multiply_divide_register_unit regression: fail");
					$finish;
				end
			end
		end
	end

	// Main sequence: reset, directed table, random sequences, drain.
	initial begin
		bit drained;
		drained = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int row = 0; row < DIRECTED_COUNT; row++)
			send_request(DIRECTED_ROWS[row].cmd, DIRECTED_ROWS[row].off,
				DIRECTED_ROWS[row].data, DIRECTED_ROWS[row].fixed, DIRECTED_ROWS[row].want);

		while (sent_count < TOTAL_REQUESTS) begin
			// Calm stretches, with no random idling, come and go; the tail is all calm.
			if (sent_count >= TOTAL_REQUESTS - CALM_TAIL)
				calm = 1'b1;
			else if ($urandom_range(0, 39) == 0)
				calm = !calm;
			if (!drained && sent_count >= TOTAL_REQUESTS / 2) begin
				wait_for_drain();
				drained = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: run_multiply_sequence();
				4, 5, 6, 7: run_divide_sequence();
				default:    run_stray_accesses();
			endcase
		end

		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("multiply_divide_register_unit regression: pass");
		else
			$display("multiply_divide_register_unit regression: fail");
		$finish;
	end

endmodule
